// ===== rtl/core/cdg_pkg.sv =====
// Shared constants and types for the central-difference gradient core.
package cdg_pkg;

  // Default sizes
  localparam int MAX_ROWS_DEF   = 1024;
  localparam int MAX_COLS_DEF   = 1024;
  localparam int PIXEL_BITS_DEF = 16;

  // Fixed result field widths
  localparam int POS_OUT_W = 10;
  localparam int GRAD_W    = 17;
  localparam int MAG_W     = 17;
  localparam int TOTAL_W   = 37;
  localparam int SUM_W     = 38;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [MAG_W-1:0]      MAG_MAX         = '1;
  localparam logic [CFG_DATA_W-1:0] PLANE_SIZE_RST  = 11'd1024;
  localparam int                    PLANE_SIZE_MIN  = 3;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLANE_ROWS  = 2'd0,
    CFG_PLANE_COLS  = 2'd1,
    CFG_NORM_SELECT = 2'd2
  } cfg_idx_t;

  // Magnitude modes
  typedef enum logic {
    NORM_EUCLID = 1'b0,
    NORM_ABS    = 1'b1
  } norm_mode_t;

endpackage

// ===== rtl/core/cdg_pix_if.sv =====
// Pixel input channel: valid/ready with one pixel sample.
interface cdg_pix_if #(
  parameter int PIXEL_BITS = cdg_pkg::PIXEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

// ===== rtl/core/cdg_res_if.sv =====
// Result channel: valid/ready with one gradient result.
interface cdg_res_if;
  logic                                valid;
  logic                                ready;
  logic [cdg_pkg::POS_OUT_W-1:0]       out_row;
  logic [cdg_pkg::POS_OUT_W-1:0]       out_col;
  logic signed [cdg_pkg::GRAD_W-1:0]   grad_x;
  logic signed [cdg_pkg::GRAD_W-1:0]   grad_y;
  logic [cdg_pkg::MAG_W-1:0]           magnitude;
  logic [cdg_pkg::TOTAL_W-1:0]         norm_total;
  logic                                plane_done;
  logic                                last_of_run;

  modport source (output valid, output out_row, output out_col, output grad_x,
                  output grad_y, output magnitude, output norm_total,
                  output plane_done, output last_of_run, input ready);
  modport sink   (input valid, input out_row, input out_col, input grad_x,
                  input grad_y, input magnitude, input norm_total,
                  input plane_done, input last_of_run, output ready);
endinterface

// ===== rtl/core/cdg_cfg_if.sv =====
// Configuration write channel: valid/ready with register index and data.
interface cdg_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cdg_pkg::CFG_IDX_W-1:0]  index;
  logic [cdg_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/central_diff_gradient_2d_core.sv =====
// Central-difference gradient core: pixel stream in, gradient results out.
//
// Pixels of one plane arrive on in_pix in row-major order (column fastest).
// For each pixel of row r (r >= 1) the core emits the result of pixel (r-1,c);
// during the last row each pixel also emits its own all-zero border result.
// A result carries row, column, grad_x, grad_y, magnitude, the running total
// of magnitudes over the plane, plane_done on the plane's final result and
// last_of_run on the last result caused by a pixel.
// Processing: one pixel is worked on at a time. A row-0 pixel is only stored and
// the core stays in S_IDLE. With the absolute-sum norm a pixel passes S_GRAD,
// S_SQ and S_EMIT1; with the euclidean norm it passes S_GRAD, S_SQ, S_SUM, S_ROOT
// and S_EMIT1, where the bit-serial square root yields one root bit per cycle; a
// second result adds S_EMIT2. The first result is registered in S_EMIT1.
// Two line stores (single write, dual read, registered read data) hold the
// two previous rows; their reads are issued on the input transfer itself.
// cfg_wr writes plane_rows, plane_cols and norm_select; write only when idle.
// Reset (synchronous, rst_n low) clears positions and the running total and
// sets the registers to 1024 / 1024 / euclidean; line stores are not cleared.
// A stalled receiver holds the result register; the core takes the next pixel
// meanwhile and waits only when the next result is ready to be registered.
module central_diff_gradient_2d_core #(
  parameter int MAX_ROWS   = cdg_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = cdg_pkg::MAX_COLS_DEF,
  parameter int PIXEL_BITS = cdg_pkg::PIXEL_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  cdg_pix_if.sink   in_pix,
  cdg_res_if.source out_res,
  cdg_cfg_if.sink   cfg_wr
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int SZW   = cdg_pkg::CFG_DATA_W + 2;
  localparam int PB    = PIXEL_BITS;
  localparam int NR    = PB + 1;
  localparam int SQW   = 2 * PB;
  localparam int RADW  = 2 * NR;
  localparam int CNTW  = $clog2(NR + 1);
  localparam int MXW   = (NR > cdg_pkg::MAG_W) ? NR : cdg_pkg::MAG_W;
  localparam int PW    = cdg_pkg::POS_OUT_W;
  localparam int GW    = cdg_pkg::GRAD_W;
  localparam int MW    = cdg_pkg::MAG_W;
  localparam int TW    = cdg_pkg::TOTAL_W;
  localparam int SW    = cdg_pkg::SUM_W;

  typedef enum logic [2:0] {
    S_IDLE, S_GRAD, S_SQ, S_SUM, S_ROOT, S_EMIT1, S_EMIT2
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [cdg_pkg::CFG_DATA_W-1:0] plane_rows_r, plane_cols_r;
  logic                           norm_sel_r;

  // Plane position state
  logic [RW-1:0]  row_pos_r;
  logic [CW-1:0]  col_pos_r;
  logic           toggle_r;
  logic [SW-1:0]  run_sum_r;

  // Item registers
  logic [RW-1:0]  it_row_r;
  logic [CW-1:0]  it_col_r;
  logic           it_toggle_r, it_row_end_r, it_last_row_r, it_border_r;
  logic [PB-1:0]  it_pix_r;

  // Line store read data
  logic [PB-1:0]  a_rd0_r, a_rd1_r, b_rd0_r, b_rd1_r;

  // Datapath registers
  logic signed [PB:0] gx_r, gy_r;
  logic [PB-1:0]      ax_r, ay_r;
  logic [SQW-1:0]     sqx_r, sqy_r;
  logic [RADW-1:0]    rad_r;
  logic [NR:0]        rem_r;
  logic [NR-1:0]      root_r;
  logic [CNTW-1:0]    cnt_r;
  logic [MW-1:0]      mag_r;

  // Result register
  logic               out_valid_r;
  logic [PW-1:0]      out_row_r, out_col_r;
  logic signed [GW-1:0] grad_x_r, grad_y_r;
  logic [MW-1:0]      magnitude_r;
  logic [TW-1:0]      norm_total_r;
  logic               plane_done_r, last_of_run_r;

  // Line stores
  logic [PB-1:0] line_store_a [MAX_COLS];
  logic [PB-1:0] line_store_b [MAX_COLS];

  logic accept;
  assign in_pix.ready = (state_r == S_IDLE);
  assign accept       = in_pix.valid && in_pix.ready;
  assign cfg_wr.ready = 1'b1;

  // Effective plane size, clamped to 3..max
  logic [SZW-1:0] rows_ext, cols_ext, rows_lim, cols_lim;
  logic           row_end, last_row;

  always_comb begin
    rows_ext = SZW'(plane_rows_r);
    cols_ext = SZW'(plane_cols_r);
    if (rows_ext < SZW'(cdg_pkg::PLANE_SIZE_MIN)) begin
      rows_lim = SZW'(cdg_pkg::PLANE_SIZE_MIN);
    end else if (rows_ext > SZW'(MAX_ROWS)) begin
      rows_lim = SZW'(MAX_ROWS);
    end else begin
      rows_lim = rows_ext;
    end
    if (cols_ext < SZW'(cdg_pkg::PLANE_SIZE_MIN)) begin
      cols_lim = SZW'(cdg_pkg::PLANE_SIZE_MIN);
    end else if (cols_ext > SZW'(MAX_COLS)) begin
      cols_lim = SZW'(MAX_COLS);
    end else begin
      cols_lim = cols_ext;
    end
    row_end  = SZW'(col_pos_r) >= (cols_lim - SZW'(1));
    last_row = SZW'(row_pos_r) >= (rows_lim - SZW'(1));
  end

  // Neighbour addresses; wrap-around only happens on border pixels
  logic [CW-1:0] col_inc, col_dec;
  assign col_inc = col_pos_r + 1'b1;
  assign col_dec = col_pos_r - 1'b1;

  // Store A: older row when toggle is set, else previous row
  always_ff @(posedge clk) begin
    if (accept) begin
      if (toggle_r) begin
        line_store_a[col_pos_r] <= in_pix.pixel_value;
      end
      a_rd0_r <= line_store_a[toggle_r ? col_pos_r : col_inc];
      a_rd1_r <= line_store_a[col_dec];
    end
  end

  // Store B: the other role
  always_ff @(posedge clk) begin
    if (accept) begin
      if (!toggle_r) begin
        line_store_b[col_pos_r] <= in_pix.pixel_value;
      end
      b_rd0_r <= line_store_b[toggle_r ? col_inc : col_pos_r];
      b_rd1_r <= line_store_b[col_dec];
    end
  end

  // Differences from the line store data
  logic [PB-1:0]      older_v, prev_hi, prev_lo;
  logic signed [PB:0] gx_nxt, gy_nxt;
  logic [PB-1:0]      ax_nxt, ay_nxt;

  always_comb begin
    older_v = it_toggle_r ? a_rd0_r : b_rd0_r;
    prev_hi = it_toggle_r ? b_rd0_r : a_rd0_r;
    prev_lo = it_toggle_r ? b_rd1_r : a_rd1_r;
    gx_nxt  = $signed({1'b0, it_pix_r}) - $signed({1'b0, older_v});
    gy_nxt  = $signed({1'b0, prev_hi}) - $signed({1'b0, prev_lo});
    ax_nxt  = (it_pix_r >= older_v) ? (it_pix_r - older_v) : (older_v - it_pix_r);
    ay_nxt  = (prev_hi >= prev_lo) ? (prev_hi - prev_lo) : (prev_lo - prev_hi);
    if (it_border_r) begin
      gx_nxt = '0;
      gy_nxt = '0;
      ax_nxt = '0;
      ay_nxt = '0;
    end
  end

  // One square-root step: one root bit per cycle
  logic [NR+2:0] sq_cand, sq_sub;
  logic          sq_ge;
  logic [NR:0]   rem_nxt;
  logic [NR-1:0] root_nxt;

  always_comb begin
    sq_cand  = {rem_r, rad_r[RADW-1 -: 2]};
    sq_sub   = (NR+3)'({root_r, 2'b01});
    sq_ge    = sq_cand >= sq_sub;
    rem_nxt  = sq_ge ? (NR+1)'(sq_cand - sq_sub) : (NR+1)'(sq_cand);
    root_nxt = {root_r[NR-2:0], sq_ge};
  end

  // Magnitude saturation to the result width
  logic [NR-1:0] abs_sum, mag_src;
  logic [MW-1:0] mag_sat;

  always_comb begin
    abs_sum = NR'(ax_r) + NR'(ay_r);
    mag_src = (state_r == S_ROOT) ? root_nxt : abs_sum;
    mag_sat = (MXW'(mag_src) > MXW'(cdg_pkg::MAG_MAX)) ? cdg_pkg::MAG_MAX : MW'(mag_src);
  end

  logic          out_free;
  logic          emit_now;
  logic [SW-1:0] sum_nxt;
  assign out_free = !out_valid_r || out_res.ready;
  assign emit_now = ((state_r == S_EMIT1) || (state_r == S_EMIT2)) && out_free;
  assign sum_nxt  = run_sum_r + SW'(mag_r);

  // Control, datapath and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      row_pos_r    <= '0;
      col_pos_r    <= '0;
      toggle_r     <= 1'b0;
      run_sum_r    <= '0;
      plane_rows_r <= cdg_pkg::PLANE_SIZE_RST;
      plane_cols_r <= cdg_pkg::PLANE_SIZE_RST;
      norm_sel_r   <= cdg_pkg::NORM_EUCLID;
    end else begin
      // Configuration writes
      if (cfg_wr.valid) begin
        unique case (cdg_pkg::cfg_idx_t'(cfg_wr.index))
          cdg_pkg::CFG_PLANE_ROWS:  plane_rows_r <= cfg_wr.data;
          cdg_pkg::CFG_PLANE_COLS:  plane_cols_r <= cfg_wr.data;
          cdg_pkg::CFG_NORM_SELECT: norm_sel_r   <= cfg_wr.data[0];
          default: ;
        endcase
      end

      // Result leaves unless a new one is registered this cycle
      if (out_res.ready && !emit_now) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            it_row_r      <= row_pos_r;
            it_col_r      <= col_pos_r;
            it_toggle_r   <= toggle_r;
            it_row_end_r  <= row_end;
            it_last_row_r <= last_row;
            it_pix_r      <= in_pix.pixel_value;
            it_border_r   <= (row_pos_r == RW'(1)) || (col_pos_r == '0) || row_end ||
                             (col_pos_r == CW'(MAX_COLS - 1));
            // Advance the plane position
            if (row_end) begin
              col_pos_r <= '0;
              if (last_row) begin
                row_pos_r <= '0;
                toggle_r  <= 1'b0;
              end else begin
                row_pos_r <= row_pos_r + 1'b1;
                toggle_r  <= !toggle_r;
              end
            end else begin
              col_pos_r <= col_pos_r + 1'b1;
            end
            if (row_pos_r != '0) begin
              state_r <= S_GRAD;
            end else if (last_row) begin
              state_r <= S_EMIT2;
            end
          end
        end

        S_GRAD: begin
          gx_r    <= gx_nxt;
          gy_r    <= gy_nxt;
          ax_r    <= ax_nxt;
          ay_r    <= ay_nxt;
          state_r <= S_SQ;
        end

        S_SQ: begin
          if (norm_sel_r == cdg_pkg::NORM_ABS) begin
            mag_r   <= mag_sat;
            state_r <= S_EMIT1;
          end else begin
            sqx_r   <= SQW'(ax_r) * SQW'(ax_r);
            sqy_r   <= SQW'(ay_r) * SQW'(ay_r);
            state_r <= S_SUM;
          end
        end

        S_SUM: begin
          rad_r   <= RADW'(sqx_r) + RADW'(sqy_r);
          rem_r   <= '0;
          root_r  <= '0;
          cnt_r   <= '0;
          state_r <= S_ROOT;
        end

        S_ROOT: begin
          rad_r  <= rad_r << 2;
          rem_r  <= rem_nxt;
          root_r <= root_nxt;
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == CNTW'(NR - 1)) begin
            mag_r   <= mag_sat;
            state_r <= S_EMIT1;
          end
        end

        // Result for the pixel one row up
        S_EMIT1: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_row_r     <= PW'(it_row_r - 1'b1);
            out_col_r     <= PW'(it_col_r);
            grad_x_r      <= GW'(gx_r);
            grad_y_r      <= GW'(gy_r);
            magnitude_r   <= mag_r;
            norm_total_r  <= sum_nxt[TW-1:0];
            plane_done_r  <= 1'b0;
            last_of_run_r <= !it_last_row_r;
            run_sum_r     <= sum_nxt;
            state_r       <= it_last_row_r ? S_EMIT2 : S_IDLE;
          end
        end

        // Last-row border result for the pixel itself
        S_EMIT2: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_row_r     <= PW'(it_row_r);
            out_col_r     <= PW'(it_col_r);
            grad_x_r      <= '0;
            grad_y_r      <= '0;
            magnitude_r   <= '0;
            norm_total_r  <= run_sum_r[TW-1:0];
            plane_done_r  <= it_row_end_r;
            last_of_run_r <= 1'b1;
            if (it_row_end_r) begin
              run_sum_r <= '0;
            end
            state_r <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.out_row     = out_row_r;
  assign out_res.out_col     = out_col_r;
  assign out_res.grad_x      = grad_x_r;
  assign out_res.grad_y      = grad_y_r;
  assign out_res.magnitude   = magnitude_r;
  assign out_res.norm_total  = norm_total_r;
  assign out_res.plane_done  = plane_done_r;
  assign out_res.last_of_run = last_of_run_r;

endmodule
